// ===== design/v3au_pkg.sv =====
// Shared types, codes and helpers of the 3-element vector arithmetic unit.
// No dependencies; compile first.
package v3au_pkg;

  localparam int W      = 32;
  localparam int DIM    = 3;
  localparam int NCROSS = 6;
  localparam int RAD_W  = 64;
  localparam int ROOT_W = 32;

  localparam logic [W-1:0]  S32MAX = 32'h7FFF_FFFF;
  localparam logic [W-1:0]  S32MIN = 32'h8000_0000;
  localparam logic [W-2:0]  U31MAX = 31'h7FFF_FFFF;

  typedef enum logic [4:0] {
    CMD_VADD, CMD_VSUB, CMD_VMUL, CMD_VDIV, CMD_VMOD,
    CMD_SADD, CMD_SSUB, CMD_SMUL, CMD_SDIV, CMD_SMOD,
    CMD_CLAMP, CMD_ABS, CMD_SIGN, CMD_DOT, CMD_CROSS,
    CMD_NORM, CMD_MAG, CMD_CMP
  } cmd_e;

  typedef enum logic [1:0] {ST_OK, ST_DIVZ, ST_OVF, ST_ZLEN} status_e;
  typedef enum logic [1:0] {ORD_LT, ORD_EQ, ORD_GT} order_e;

  typedef struct packed {
    logic [4:0]          cmd;
    logic signed [W-1:0] a_x;
    logic signed [W-1:0] a_y;
    logic signed [W-1:0] a_z;
    logic signed [W-1:0] b_x;
    logic signed [W-1:0] b_y;
    logic signed [W-1:0] b_z;
    logic signed [W-1:0] c_x;
    logic signed [W-1:0] c_y;
    logic signed [W-1:0] c_z;
    logic signed [W-1:0] scalar_in;
  } in_t;

  typedef struct packed {
    logic signed [W-1:0] r_x;
    logic signed [W-1:0] r_y;
    logic signed [W-1:0] r_z;
    logic signed [W-1:0] scalar_out;
    logic [W-2:0]        mag_out;
    logic [W-2:0]        mag_sq_out;
    logic [1:0]          order;
    logic [1:0]          status;
  } out_t;

  // Context ahead of the divider
  typedef struct packed {
    logic [4:0]                cmd;
    logic [DIM-1:0][W-1:0]     a;
    logic [DIM-1:0][W-1:0]     y;
    logic [DIM-1:0][W-1:0]     r;
    logic [W-1:0]              dot;
    logic [1:0]                order;
    logic                      ovf;
  } ctx_t;

  // Context through the divider
  typedef struct packed {
    logic [4:0]            cmd;
    logic [DIM-1:0][W-1:0] r;
    logic [W-1:0]          dot;
    logic [1:0]            order;
    logic                  ovf;
    logic [DIM-1:0]        qneg;
    logic [DIM-1:0]        xneg;
    logic [DIM-1:0]        xzero;
    logic [DIM-1:0]        dzero;
  } ctx2_t;

  // Saturate to 32 bits signed; MSB of the result flags overflow
  function automatic logic [W:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return {1'b1, S32MAX};
    end else if (v < -66'sd2147483648) begin
      return {1'b1, S32MIN};
    end
    return {1'b0, v[W-1:0]};
  endfunction

endpackage

// ===== design/v3au_in_if.sv =====
// Input channel of the vector unit: valid/ready handshake with an in_t payload.
// Depends on v3au_pkg.
interface v3au_in_if;
  import v3au_pkg::*;
  logic valid;
  logic ready;
  in_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/v3au_out_if.sv =====
// Result channel of the vector unit: valid/ready handshake with an out_t payload.
// Depends on v3au_pkg.
interface v3au_out_if;
  import v3au_pkg::*;
  logic valid;
  logic ready;
  out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/vector3_arith_unit_top.sv =====
// Top level of the 3-element Q-format vector arithmetic unit.
// Depends on v3au_pkg, v3au_in_if, v3au_out_if and v3au_isqrt.
//
// Usage:
//   item_i carries one command with vectors a, b, c and a scalar; result_o
//   returns one result per command: vector r, dot product, magnitude,
//   squared magnitude, compare order and status.
//   A transfer happens on a rising edge with valid and ready both high.
//   Throughput: one item per cycle with any mix of commands, sustained while
//   the output register is taken or empty. Pipeline depth is set by the two
//   32-stage square root pipelines (input length for normalize, result
//   magnitude) and the divider, which resolves one quotient bit per stage
//   over 32 + FRAC_BITS stages. The default FRAC_BITS of 16 gives Q16.16.
//   Every stage holds when the output register is full and not taken, so a
//   stalled receiver freezes the whole pipeline: nothing is dropped or
//   repeated. Empty stages still advance while the output register is empty.
//   Reset clears all valid bits at once; the unit is ready as soon as reset
//   is released.
module vector3_arith_unit_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  v3au_in_if.sink     item_i,
  v3au_out_if.source  result_o
);
  import v3au_pkg::*;

  localparam int DW = W + FRAC_BITS;
  localparam logic signed [W-1:0]  ONE_S   = W'(64'sd1 <<< FRAC_BITS);
  localparam logic signed [W-1:0]  NEG_ONE = -ONE_S;
  localparam logic signed [65:0]   HALF66  = 66'sd1 <<< (FRAC_BITS - 1);
  localparam logic [64:0]          HALF65  = 65'd1 << (FRAC_BITS - 1);

  // Divider stage payload: dividend bits shift out as quotient bits shift in
  typedef struct packed {
    logic [DIM-1:0][DW-1:0] nq;
    logic [DIM-1:0][W-1:0]  rem;
    logic [DIM-1:0][W-1:0]  d;
  } dv_t;

  function automatic dv_t dv_step(input dv_t s);
    dv_t        o;
    logic [W:0] rs;
    o = s;
    for (int i = 0; i < DIM; i++) begin
      rs = {s.rem[i], s.nq[i][DW-1]};
      if (rs >= {1'b0, s.d[i]}) begin
        o.rem[i] = W'(rs - {1'b0, s.d[i]});
        o.nq[i]  = {s.nq[i][DW-2:0], 1'b1};
      end else begin
        o.rem[i] = rs[W-1:0];
        o.nq[i]  = {s.nq[i][DW-2:0], 1'b0};
      end
    end
    return o;
  endfunction

  // Global advance: the whole pipeline moves unless the output is blocked
  logic adv;
  logic out_v_q;
  out_t out_q;

  assign adv          = !out_v_q || result_o.ready;
  assign item_i.ready = adv;

  // ---------------------------------------------------------------------
  // Stage 1: capture the input transfer
  // ---------------------------------------------------------------------
  logic s1_v_q;
  in_t  s1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q <= item_i.data;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: multipliers, plus the single-step ops (add, sub, clamp, abs,
  // sign, pass-through, compare)
  // ---------------------------------------------------------------------
  logic signed [W-1:0] a [DIM];
  logic signed [W-1:0] b [DIM];
  logic signed [W-1:0] c [DIM];
  ctx_t                s2_d;
  logic signed [63:0]  pe_d [DIM];
  logic signed [63:0]  pc_d [NCROSS];

  always_comb begin
    a[0] = s1_q.a_x;  a[1] = s1_q.a_y;  a[2] = s1_q.a_z;
    b[0] = s1_q.b_x;  b[1] = s1_q.b_y;  b[2] = s1_q.b_z;
    c[0] = s1_q.c_x;  c[1] = s1_q.c_y;  c[2] = s1_q.c_z;
  end

  always_comb begin
    logic                is_scl;
    logic signed [W-1:0] opr;
    logic signed [W-1:0] rhs;
    logic signed [W-1:0] mx;
    logic signed [W:0]   sum33;
    logic [W:0]          sr;
    is_scl   = s1_q.cmd inside {[CMD_SADD:CMD_SMOD]};
    s2_d     = '0;
    s2_d.cmd = s1_q.cmd;
    opr      = '0;
    rhs      = '0;
    mx       = '0;
    sum33    = '0;
    sr       = '0;
    if (s1_q.cmd == CMD_CMP) begin
      s2_d.order = ORD_EQ;
      // scan from the last element so the first difference wins
      for (int i = DIM - 1; i >= 0; i--) begin
        if (a[i] != b[i]) begin
          s2_d.order = (a[i] < b[i]) ? ORD_LT : ORD_GT;
        end
      end
    end
    for (int i = 0; i < DIM; i++) begin
      opr        = is_scl ? s1_q.scalar_in : b[i];
      rhs        = (s1_q.cmd == CMD_NORM) ? a[i] : opr;
      pe_d[i]    = a[i] * rhs;
      s2_d.a[i]  = a[i];
      s2_d.y[i]  = opr;
      case (s1_q.cmd)
        CMD_VADD, CMD_SADD: begin
          sum33      = a[i] + opr;
          sr         = sat32(66'(sum33));
          s2_d.r[i]  = sr[W-1:0];
          s2_d.ovf   = s2_d.ovf | sr[W];
        end
        CMD_VSUB, CMD_SSUB: begin
          sum33      = a[i] - opr;
          sr         = sat32(66'(sum33));
          s2_d.r[i]  = sr[W-1:0];
          s2_d.ovf   = s2_d.ovf | sr[W];
        end
        CMD_CLAMP: begin
          mx         = (a[i] > b[i]) ? a[i] : b[i];
          s2_d.r[i]  = (mx < c[i]) ? mx : c[i];
        end
        CMD_ABS: begin
          if (a[i] == $signed(S32MIN)) begin
            s2_d.r[i] = S32MAX;
            s2_d.ovf  = 1'b1;
          end else begin
            s2_d.r[i] = a[i][W-1] ? -a[i] : a[i];
          end
        end
        CMD_SIGN: begin
          s2_d.r[i] = (a[i] > 0) ? ONE_S : ((a[i] < 0) ? NEG_ONE : '0);
        end
        CMD_MAG: begin
          s2_d.r[i] = a[i];
        end
        default: begin
        end
      endcase
    end
    pc_d[0] = a[1] * b[2];
    pc_d[1] = a[2] * b[1];
    pc_d[2] = a[2] * b[0];
    pc_d[3] = a[0] * b[2];
    pc_d[4] = a[0] * b[1];
    pc_d[5] = a[1] * b[0];
  end

  logic               s2_v_q;
  ctx_t               s2_q;
  logic signed [63:0] s2_pe_q [DIM];
  logic signed [63:0] s2_pc_q [NCROSS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (adv) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_q    <= s2_d;
      s2_pe_q <= pe_d;
      s2_pc_q <= pc_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: round products (mul, dot, cross); sum of squares for normalize
  // ---------------------------------------------------------------------
  ctx_t             s3_d;
  logic [RAD_W-1:0] rad_d;

  always_comb begin
    logic [W:0] sr;
    s3_d  = s2_q;
    sr    = '0;
    rad_d = RAD_W'($unsigned(s2_pe_q[0])) + RAD_W'($unsigned(s2_pe_q[1]))
          + RAD_W'($unsigned(s2_pe_q[2]));
    case (s2_q.cmd)
      CMD_VMUL, CMD_SMUL: begin
        for (int i = 0; i < DIM; i++) begin
          sr         = sat32((66'(s2_pe_q[i]) + HALF66) >>> FRAC_BITS);
          s3_d.r[i]  = sr[W-1:0];
          s3_d.ovf   = s3_d.ovf | sr[W];
        end
      end
      CMD_DOT: begin
        sr = sat32((66'(s2_pe_q[0]) + 66'(s2_pe_q[1]) + 66'(s2_pe_q[2]) + HALF66)
                   >>> FRAC_BITS);
        s3_d.dot = sr[W-1:0];
        s3_d.ovf = s3_d.ovf | sr[W];
      end
      CMD_CROSS: begin
        for (int i = 0; i < DIM; i++) begin
          sr = sat32((66'(s2_pc_q[2*i]) - 66'(s2_pc_q[2*i+1]) + HALF66) >>> FRAC_BITS);
          s3_d.r[i] = sr[W-1:0];
          s3_d.ovf  = s3_d.ovf | sr[W];
        end
      end
      default: begin
      end
    endcase
  end

  logic             s3_v_q;
  ctx_t             s3_q;
  logic [RAD_W-1:0] s3_rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (adv) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_q     <= s3_d;
      s3_rad_q <= rad_d;
    end
  end

  // ---------------------------------------------------------------------
  // Length of a for normalize; the context rides along as the tag
  // ---------------------------------------------------------------------
  logic [$bits(ctx_t)-1:0] s3_tag;
  logic [$bits(ctx_t)-1:0] qa_tag;
  logic                    qa_v;
  logic [ROOT_W-1:0]       qa_root;
  ctx_t                    qa_ctx;

  assign s3_tag = s3_q;
  assign qa_ctx = qa_tag;

  v3au_isqrt #(
    .TAG_W ($bits(ctx_t))
  ) u_sqrt_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s3_v_q),
    .rad_i   (s3_rad_q),
    .tag_i   (s3_tag),
    .valid_o (qa_v),
    .root_o  (qa_root),
    .tag_o   (qa_tag)
  );

  // ---------------------------------------------------------------------
  // Divider entry: magnitudes, dividend alignment and sign bookkeeping
  // ---------------------------------------------------------------------
  ctx2_t c4_d;
  dv_t   dv0_d;

  always_comb begin
    logic         is_norm;
    logic         is_mod;
    logic [W-1:0] x;
    logic [W-1:0] y;
    logic [W-1:0] xm;
    logic [W-1:0] ym;
    is_norm    = (qa_ctx.cmd == CMD_NORM);
    is_mod     = (qa_ctx.cmd == CMD_VMOD) || (qa_ctx.cmd == CMD_SMOD);
    c4_d       = '0;
    c4_d.cmd   = qa_ctx.cmd;
    c4_d.r     = qa_ctx.r;
    c4_d.dot   = qa_ctx.dot;
    c4_d.order = qa_ctx.order;
    c4_d.ovf   = qa_ctx.ovf;
    dv0_d      = '0;
    for (int i = 0; i < DIM; i++) begin
      x  = qa_ctx.a[i];
      y  = qa_ctx.y[i];
      xm = x[W-1] ? (~x + 1'b1) : x;
      ym = y[W-1] ? (~y + 1'b1) : y;
      dv0_d.d[i]     = is_norm ? qa_root : ym;
      dv0_d.nq[i]    = is_mod ? DW'(xm) : {xm, {FRAC_BITS{1'b0}}};
      c4_d.qneg[i]   = is_norm ? x[W-1] : (x[W-1] ^ y[W-1]);
      c4_d.xneg[i]   = x[W-1];
      c4_d.xzero[i]  = (x == '0);
      c4_d.dzero[i]  = (dv0_d.d[i] == '0);
    end
  end

  // Divider pipeline: entry register plus one quotient bit per stage
  dv_t         dv_q [DW+1];
  ctx2_t       c2_q [DW+1];
  logic [DW:0] dv_v_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_q[0] <= dv0_d;
      c2_q[0] <= c4_d;
      for (int k = 1; k <= DW; k++) begin
        dv_q[k] <= dv_step(dv_q[k-1]);
        c2_q[k] <= c2_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v_q <= '0;
    end else if (adv) begin
      dv_v_q <= {dv_v_q[DW-1:0], qa_v};
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: apply signs, divide-by-zero and zero-length rules, status
  // ---------------------------------------------------------------------
  out_t o5_d;

  always_comb begin
    ctx2_t              cx;
    dv_t                dq;
    logic [DIM-1:0][W-1:0] r;
    logic               dz;
    logic               ovf;
    logic               zlen;
    logic signed [65:0] qx;
    logic signed [65:0] qs;
    logic signed [65:0] rx;
    logic signed [65:0] rsn;
    logic [W:0]         sr;
    cx   = c2_q[DW];
    dq   = dv_q[DW];
    r    = cx.r;
    dz   = 1'b0;
    ovf  = cx.ovf;
    zlen = 1'b0;
    qx   = '0;
    qs   = '0;
    rx   = '0;
    rsn  = '0;
    sr   = '0;
    for (int i = 0; i < DIM; i++) begin
      qx  = $signed(66'(dq.nq[i]));
      qs  = cx.qneg[i] ? -qx : qx;
      rx  = $signed(66'(dq.rem[i]));
      rsn = cx.xneg[i] ? -rx : rx;
      case (cx.cmd)
        CMD_VDIV, CMD_SDIV: begin
          if (cx.dzero[i]) begin
            dz   = 1'b1;
            r[i] = cx.xneg[i] ? S32MIN : (cx.xzero[i] ? '0 : S32MAX);
          end else begin
            sr   = sat32(qs);
            r[i] = sr[W-1:0];
            ovf  = ovf | sr[W];
          end
        end
        CMD_VMOD, CMD_SMOD: begin
          if (cx.dzero[i]) begin
            dz   = 1'b1;
            r[i] = '0;
          end else begin
            r[i] = rsn[W-1:0];
          end
        end
        CMD_NORM: begin
          if (cx.dzero[i]) begin
            zlen = 1'b1;
            r[i] = S32MAX;
          end else begin
            r[i] = qs[W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
    o5_d            = '0;
    o5_d.r_x        = r[0];
    o5_d.r_y        = r[1];
    o5_d.r_z        = r[2];
    o5_d.scalar_out = cx.dot;
    o5_d.order      = cx.order;
    if (dz) begin
      o5_d.status = ST_DIVZ;
    end else if (ovf) begin
      o5_d.status = ST_OVF;
    end else if (zlen) begin
      o5_d.status = ST_ZLEN;
    end else begin
      o5_d.status = ST_OK;
    end
  end

  logic s5_v_q;
  out_t s5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_v_q <= 1'b0;
    end else if (adv) begin
      s5_v_q <= dv_v_q[DW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s5_q <= o5_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stages 6 and 7: square the result elements, then sum them
  // ---------------------------------------------------------------------
  logic               s6_v_q;
  out_t               s6_q;
  logic signed [63:0] s6_sq_q [DIM];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_v_q <= 1'b0;
    end else if (adv) begin
      s6_v_q <= s5_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s6_q       <= s5_q;
      s6_sq_q[0] <= s5_q.r_x * s5_q.r_x;
      s6_sq_q[1] <= s5_q.r_y * s5_q.r_y;
      s6_sq_q[2] <= s5_q.r_z * s5_q.r_z;
    end
  end

  logic             s7_v_q;
  out_t             s7_q;
  logic [RAD_W-1:0] s7_ssq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_v_q <= 1'b0;
    end else if (adv) begin
      s7_v_q <= s6_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s7_q     <= s6_q;
      s7_ssq_q <= RAD_W'($unsigned(s6_sq_q[0])) + RAD_W'($unsigned(s6_sq_q[1]))
                + RAD_W'($unsigned(s6_sq_q[2]));
    end
  end

  // Squared magnitude in Q format, rounded half up, saturated to 31 bits
  logic [64:0] msq_full;
  logic [64:0] msq_sh;
  out_t        s7_tag;

  always_comb begin
    msq_full          = {1'b0, s7_ssq_q} + HALF65;
    msq_sh            = msq_full >> FRAC_BITS;
    s7_tag            = s7_q;
    s7_tag.mag_sq_out = (|msq_sh[64:W-1]) ? U31MAX : msq_sh[W-2:0];
  end

  // ---------------------------------------------------------------------
  // Magnitude of the result vector
  // ---------------------------------------------------------------------
  logic [$bits(out_t)-1:0] s7_tag_bits;
  logic [$bits(out_t)-1:0] qr_tag;
  logic                    qr_v;
  logic [ROOT_W-1:0]       qr_root;
  out_t                    qr_res;

  assign s7_tag_bits = s7_tag;
  assign qr_res      = qr_tag;

  v3au_isqrt #(
    .TAG_W ($bits(out_t))
  ) u_sqrt_r (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s7_v_q),
    .rad_i   (s7_ssq_q),
    .tag_i   (s7_tag_bits),
    .valid_o (qr_v),
    .root_o  (qr_root),
    .tag_o   (qr_tag)
  );

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  out_t out_d;

  always_comb begin
    out_d         = qr_res;
    out_d.mag_out = qr_root[ROOT_W-1] ? U31MAX : qr_root[W-2:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= qr_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign result_o.valid = out_v_q;
  assign result_o.data  = out_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // A zero-length normalize leaves every element at the positive limit
  a_zlen_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && (out_q.status == ST_ZLEN) |->
      (out_q.r_x == $signed(S32MAX)) && (out_q.r_y == $signed(S32MAX)) &&
      (out_q.r_z == $signed(S32MAX)))
    else $error("zero-length normalize without saturated vector");

  // A compare result of equal or greater carries no vector
  a_order_no_vec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && (out_q.order != ORD_LT) |->
      (out_q.r_x == 0) && (out_q.r_y == 0) && (out_q.r_z == 0) &&
      (out_q.mag_out == 0) && (out_q.mag_sq_out == 0))
    else $error("compare result with non-zero vector");

  // A non-zero dot product result carries no vector and the default order ORD_LT
  a_dot_no_vec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && (out_q.scalar_out != 0) |->
      (out_q.r_x == 0) && (out_q.r_y == 0) && (out_q.r_z == 0) &&
      (out_q.order == ORD_LT))
    else $error("dot result mixed with other fields");

  // A blocked output freezes the inner stages
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(s3_v_q) && $stable(s3_q) && $stable(dv_v_q))
    else $error("pipeline moved during stall");

endmodule

// ===== design/v3au_isqrt.sv =====
// Pipelined integer square root, one root bit per stage, with a side-band tag.
// Depends on v3au_pkg.
module v3au_isqrt #(
  parameter int TAG_W = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [v3au_pkg::RAD_W-1:0]   rad_i,
  input  logic [TAG_W-1:0]             tag_i,
  output logic                         valid_o,
  output logic [v3au_pkg::ROOT_W-1:0]  root_o,
  output logic [TAG_W-1:0]             tag_o
);
  import v3au_pkg::*;

  localparam int STG   = ROOT_W;
  localparam int REM_W = ROOT_W + 3;

  typedef struct packed {
    logic [RAD_W-1:0]  x;
    logic [ROOT_W-1:0] q;
    logic [REM_W-1:0]  rem;
    logic [TAG_W-1:0]  tag;
  } sq_t;

  sq_t            st_in;
  sq_t            st_q [STG];
  logic [STG-1:0] v_q;

  function automatic sq_t sq_step(input sq_t s);
    sq_t              o;
    logic [REM_W-1:0] rs;
    logic [REM_W-1:0] trial;
    o     = s;
    rs    = {s.rem[REM_W-3:0], s.x[RAD_W-1 -: 2]};
    trial = REM_W'({s.q, 2'b01});
    o.x   = {s.x[RAD_W-3:0], 2'b00};
    if (rs >= trial) begin
      o.rem = rs - trial;
      o.q   = {s.q[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem = rs;
      o.q   = {s.q[ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

  always_comb begin
    st_in.x   = rad_i;
    st_in.q   = '0;
    st_in.rem = '0;
    st_in.tag = tag_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= sq_step(st_in);
      for (int k = 1; k < STG; k++) begin
        st_q[k] <= sq_step(st_q[k-1]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[STG-2:0], valid_i};
    end
  end

  assign valid_o = v_q[STG-1];
  assign root_o  = st_q[STG-1].q;
  assign tag_o   = st_q[STG-1].tag;

endmodule
